>>> design/fifo_process_scheduler_semaphores_macros.svh
// assertion macros shared by the scheduler modules
`ifndef FIFO_PROCESS_SCHEDULER_SEMAPHORES_MACROS_SVH
`define FIFO_PROCESS_SCHEDULER_SEMAPHORES_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FPS_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("scheduler check failed");
// next-cycle implication
`define FPS_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("scheduler check failed");
`else
`define FPS_ASSERT_IMPL(lbl, clk, rst, a, b)
`define FPS_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif

`endif

>>> design/fps_pkg.sv
package fps_pkg;

  // operation codes
  localparam logic [2:0] MODE_MAKE_READY  = 3'd0;
  localparam logic [2:0] MODE_BLOCK_CHILD = 3'd1;
  localparam logic [2:0] MODE_SEM_CREATE  = 3'd2;
  localparam logic [2:0] MODE_SEM_P       = 3'd3;
  localparam logic [2:0] MODE_SEM_V       = 3'd4;
  localparam logic [2:0] MODE_SCHEDULE    = 3'd5;
  localparam logic [2:0] MODE_SET_STATUS  = 3'd6;
  localparam logic [2:0] MODE_UNUSED      = 3'd7;

  // process status codes
  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_ZOMBIE  = 3'd4;

  // result codes
  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_SHUTDOWN = 2'd1;
  localparam logic [1:0] RC_STUCK    = 2'd2;
  localparam logic [1:0] RC_FULL     = 2'd3;

  // datapath micro-operations
  typedef enum logic [4:0] {
    U_NONE, U_LATCH, U_MR_CLR, U_BOC_W, U_CREATE, U_P_RD, U_P_CHK, U_V_RD,
    U_V_INC, U_SET, U_RM_INIT_R, U_RM_INIT_B, U_RM_RD, U_RM_CHK, U_ADD_R,
    U_ADD_B, U_WK_INIT, U_WK_TEST, U_WK_GET, U_WK_Z, U_WK_S, U_WK_UNLINK,
    U_DISP, U_DISP2, U_SC_RD, U_SC_CHK
  } uop_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MR_CLR, S_BOC_W, S_CREATE, S_P_RD, S_P_CHK, S_P_BLK,
    S_V_RD, S_V_INC, S_SET, S_RM_INIT_R, S_RM_INIT_B, S_RM_RD, S_RM_CHK,
    S_ADD_R, S_ADD_B, S_WK_INIT, S_WK_TEST, S_WK_GET, S_WK_Z, S_WK_S,
    S_WK_UNLINK, S_DISP, S_DISP2, S_SC_RD, S_SC_CHK, S_FIN
  } state_t;

  typedef struct packed {
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       tgt_ok;
    logic       sem_ok;
    logic       subj_in_rdy;
    logic       subj_in_blk;
    logic       rm_hit;
    logic       cnt_zero;
    logic       wk_cand;
    logic       st_zombie;
    logic       cnt_nonzero;
    logic       run_v;
    logic       rdy_empty;
    logic       sc_stop;
  } stat_t;

endpackage

>>> design/fps_dp.sv
`include "fifo_process_scheduler_semaphores_macros.svh"

module fps_dp #(
  parameter int PROC_SLOTS = 32,
  parameter int SEM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  fps_pkg::cmd_t    cmd,
  output fps_pkg::stat_t   stat,
  input  logic [2:0]       mode,
  input  logic [4:0]       target_proc,
  input  logic [4:0]       child_proc,
  input  logic [3:0]       sem_select,
  input  logic [15:0]      sem_init,
  input  logic [2:0]       new_status,
  output logic [1:0]       result_code,
  output logic             run_valid,
  output logic [4:0]       run_proc,
  output logic [3:0]       sem_created
);
  import fps_pkg::*;

  localparam int PW = $clog2(PROC_SLOTS);
  localparam int LW = $clog2(PROC_SLOTS + 1);
  localparam int SW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int UW = $clog2(SEM_SLOTS + 1);
  localparam int CB = COUNT_BITS;

  typedef struct packed {
    logic          aw_v;
    logic [4:0]    aw;
    logic          ws_v;
    logic [SW-1:0] ws;
  } wrec_t;

  uop_t uop;
  assign uop = cmd.uop;

  // latched request
  logic [2:0]    mode_r;
  logic [PW-1:0] tgt;
  logic          tgt_ok;
  logic [4:0]    child;
  logic [SW-1:0] sem;
  logic          sem_ok;
  logic [CB-1:0] init;
  logic [2:0]    nst;

  // list and walk registers
  logic [PROC_SLOTS-1:0] in_rdy, in_blk;
  logic [PW-1:0] rh, rt, bh, bt;
  logic [LW-1:0] rl, bl, cnt;
  logic [PW-1:0] cur, prv, sp, subj, idx, run_p;
  logic          prv_v, lsel, run_v;
  logic [UW-1:0] siu;

  // memories and their read data
  logic [2:0]    s_mem [PROC_SLOTS];
  logic [PW-1:0] l_mem [PROC_SLOTS];
  wrec_t         w_mem [PROC_SLOTS];
  logic [CB-1:0] c_mem [SEM_SLOTS];
  logic [PROC_SLOTS-1:0] s_vld, w_vld;
  logic [2:0]    s_q;
  logic [PW-1:0] l_q;
  wrec_t         w_q;
  logic [CB-1:0] c_q;

  logic          s_we, s_re, l_we, l_re, w_we, w_re, c_we, c_re;
  logic [PW-1:0] s_wa, s_ra, l_wa, l_ra, w_wa, w_ra;
  logic [SW-1:0] c_wa, c_ra;
  logic [2:0]    s_wd;
  logic [PW-1:0] l_wd;
  wrec_t         w_wd;
  logic [CB-1:0] c_wd;

  // decision terms
  logic subj_rdy, subj_blk, hit, cand, zomb, c_nz, keep, full, st_busy, last;
  logic [PW-1:0] l_tail;

  assign subj_rdy = in_rdy[subj];
  assign subj_blk = in_blk[subj];
  assign hit      = (cur == subj);
  assign cand     = (mode_r == MODE_SEM_V) ? w_q.ws_v
                  : (w_q.aw_v && (32'(w_q.aw) < PROC_SLOTS));
  assign zomb     = (s_q == ST_ZOMBIE);
  assign c_nz     = (c_q != '0);
  assign keep     = ((uop == U_WK_GET) && !cand) || ((uop == U_WK_Z) && !zomb) ||
                    ((uop == U_WK_S) && !c_nz);
  assign full     = (32'(siu) >= SEM_SLOTS);
  assign st_busy  = (s_q != ST_FREE) && (s_q != ST_ZOMBIE);
  assign last     = (idx == PW'(PROC_SLOTS - 1));
  assign l_tail   = lsel ? bt : rt;

  // status to controller
  always_comb begin
    stat.mode        = mode_r;
    stat.tgt_ok      = tgt_ok;
    stat.sem_ok      = sem_ok;
    stat.subj_in_rdy = subj_rdy;
    stat.subj_in_blk = subj_blk;
    stat.rm_hit      = hit;
    stat.cnt_zero    = (cnt == '0);
    stat.wk_cand     = cand;
    stat.st_zombie   = zomb;
    stat.cnt_nonzero = c_nz;
    stat.run_v       = run_v;
    stat.rdy_empty   = (rl == '0);
    stat.sc_stop     = st_busy || last;
  end

  // status memory ports
  always_comb begin
    s_we = 1'b0;
    s_wa = subj;
    s_wd = ST_READY;
    unique case (uop)
      U_SET:   begin s_we = tgt_ok && (nst <= ST_ZOMBIE); s_wa = tgt; s_wd = nst; end
      U_ADD_R: begin s_we = !subj_rdy; s_wd = ST_READY; end
      U_ADD_B: begin s_we = !subj_blk; s_wd = ST_BLOCKED; end
      U_DISP2: begin s_we = 1'b1; s_wa = rh; s_wd = ST_RUNNING; end
      default: ;
    endcase
    s_re = (uop == U_SC_RD) || ((uop == U_WK_GET) && cand);
    s_ra = (uop == U_SC_RD) ? idx : PW'(w_q.aw);
  end

  // link memory ports
  always_comb begin
    l_we = 1'b0;
    l_wa = prv;
    l_wd = subj;
    unique case (uop)
      U_RM_CHK:    begin l_we = hit && prv_v; l_wd = l_q; end
      U_WK_UNLINK: begin l_we = prv_v; l_wd = cur; end
      U_ADD_R:     begin l_we = !subj_rdy && (rl != '0); l_wa = rt; end
      U_ADD_B:     begin l_we = !subj_blk && (bl != '0); l_wa = bt; end
      default: ;
    endcase
    l_re = (uop == U_RM_RD) || (uop == U_WK_TEST) || ((uop == U_DISP) && (rl != '0));
    l_ra = (uop == U_DISP) ? rh : cur;
  end

  // wait record memory ports
  always_comb begin
    w_we = 1'b0;
    w_wa = sp;
    w_wd = w_q;
    unique case (uop)
      U_MR_CLR: begin w_we = 1'b1; w_wa = tgt; w_wd = '0; end
      U_BOC_W:  begin
        w_we = 1'b1; w_wa = tgt;
        w_wd = '{aw_v: 1'b1, aw: child, ws_v: 1'b0, ws: '0};
      end
      U_P_CHK:  begin
        w_we = !c_nz && run_v; w_wa = run_p;
        w_wd = '{aw_v: 1'b0, aw: '0, ws_v: 1'b1, ws: sem};
      end
      U_WK_Z:   begin w_we = zomb; w_wd.aw_v = 1'b0; end
      U_WK_S:   begin w_we = c_nz; w_wd.ws_v = 1'b0; end
      default: ;
    endcase
    w_re = (uop == U_WK_TEST) && (cnt != '0);
    w_ra = cur;
  end

  // count memory ports
  always_comb begin
    c_we = 1'b0;
    c_wa = sem;
    c_wd = c_q - 1'b1;
    unique case (uop)
      U_CREATE: begin c_we = !full; c_wa = SW'(siu); c_wd = init; end
      U_P_CHK:  c_we = c_nz;
      U_V_INC:  begin c_we = 1'b1; c_wd = (&c_q) ? c_q : c_q + 1'b1; end
      U_WK_S:   begin c_we = c_nz; c_wa = w_q.ws; end
      default: ;
    endcase
    c_re = (uop == U_P_RD) || (uop == U_V_RD) || ((uop == U_WK_GET) && cand);
    c_ra = (uop == U_WK_GET) ? w_q.ws : sem;
  end

  // memories
  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_wa] <= s_wd;
    if (s_re) s_q <= s_vld[s_ra] ? s_mem[s_ra] : ST_FREE;
    if (l_we) l_mem[l_wa] <= l_wd;
    if (l_re) l_q <= l_mem[l_ra];
    if (w_we) w_mem[w_wa] <= w_wd;
    if (w_re) w_q <= w_vld[w_ra] ? w_mem[w_ra] : '0;
    if (c_we) c_mem[c_wa] <= c_wd;
    if (c_re) c_q <= c_mem[c_ra];
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rdy <= '0;
      in_blk <= '0;
      rl     <= '0;
      bl     <= '0;
      siu    <= '0;
      run_v  <= 1'b0;
      s_vld  <= '0;
      w_vld  <= '0;
    end else begin
      if (s_we) s_vld[s_wa] <= 1'b1;
      if (w_we) w_vld[w_wa] <= 1'b1;
      unique case (uop)
        U_CREATE: if (!full) siu <= siu + 1'b1;
        U_RM_CHK: begin
          if (hit) begin
            if (lsel) begin
              in_blk[subj] <= 1'b0;
              bl <= bl - 1'b1;
            end else begin
              in_rdy[subj] <= 1'b0;
              rl <= rl - 1'b1;
            end
          end
        end
        U_ADD_R: begin
          if (!subj_rdy) begin
            in_rdy[subj] <= 1'b1;
            rl <= rl + 1'b1;
          end
        end
        U_ADD_B: begin
          if (!subj_blk) begin
            in_blk[subj] <= 1'b1;
            bl <= bl + 1'b1;
          end
        end
        U_WK_UNLINK: begin
          in_blk[sp] <= 1'b0;
          bl <= bl - 1'b1;
        end
        U_DISP: if (rl == '0) run_v <= 1'b0;
        U_DISP2: begin
          in_rdy[rh] <= 1'b0;
          rl <= rl - 1'b1;
          run_v <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request, list pointers, walk and result registers
  always_ff @(posedge clk) begin
    unique case (uop)
      U_LATCH: begin
        mode_r      <= mode;
        tgt         <= PW'(target_proc);
        subj        <= PW'(target_proc);
        tgt_ok      <= (32'(target_proc) < PROC_SLOTS);
        child       <= child_proc;
        sem         <= SW'(sem_select);
        sem_ok      <= (32'(sem_select) < SEM_SLOTS);
        init        <= CB'(sem_init);
        nst         <= new_status;
        result_code <= RC_OK;
        run_valid   <= 1'b0;
        run_proc    <= '0;
        sem_created <= '0;
      end
      U_CREATE: begin
        if (full) result_code <= RC_FULL;
        else sem_created <= 4'(siu);
      end
      U_P_CHK: if (!c_nz) subj <= run_p;
      U_RM_INIT_R: begin lsel <= 1'b0; cur <= rh; prv_v <= 1'b0; end
      U_RM_INIT_B: begin lsel <= 1'b1; cur <= bh; prv_v <= 1'b0; end
      U_RM_CHK: begin
        if (hit) begin
          if (!prv_v) begin
            if (lsel) bh <= l_q;
            else rh <= l_q;
          end
          if (cur == l_tail) begin
            if (lsel) bt <= prv;
            else rt <= prv;
          end
        end else begin
          prv   <= cur;
          prv_v <= 1'b1;
          cur   <= l_q;
        end
      end
      U_ADD_R: begin
        if (!subj_rdy) begin
          if (rl == '0) rh <= subj;
          rt <= subj;
        end
      end
      U_ADD_B: begin
        if (!subj_blk) begin
          if (bl == '0) bh <= subj;
          bt <= subj;
        end
      end
      U_WK_INIT: begin cnt <= bl; cur <= bh; prv_v <= 1'b0; end
      U_WK_TEST: sp <= cur;
      U_WK_GET: begin cur <= l_q; cnt <= cnt - 1'b1; end
      U_WK_UNLINK: begin
        if (!prv_v) bh <= cur;
        if (sp == bt) bt <= prv;
        subj <= sp;
      end
      U_DISP: idx <= '0;
      U_DISP2: begin
        rh        <= l_q;
        run_p     <= rh;
        run_valid <= 1'b1;
        run_proc  <= 5'(rh);
      end
      U_SC_CHK: begin
        if (st_busy) result_code <= RC_STUCK;
        else if (last) result_code <= RC_SHUTDOWN;
        else idx <= idx + 1'b1;
      end
      default: ;
    endcase
    // node stays on the blocked list
    if (keep) begin
      prv   <= sp;
      prv_v <= 1'b1;
    end
  end

  `FPS_ASSERT_IMPL(a_rdy_len, clk, rst, 1'b1, $countones(in_rdy) == 32'(rl))
  `FPS_ASSERT_IMPL(a_blk_len, clk, rst, 1'b1, $countones(in_blk) == 32'(bl))
  `FPS_ASSERT_IMPL(a_one_list, clk, rst, 1'b1, (in_rdy & in_blk) == '0)

endmodule

>>> design/fps_ctrl.sv
`include "fifo_process_scheduler_semaphores_macros.svh"

module fps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  fps_pkg::stat_t stat,
  output fps_pkg::cmd_t  cmd
);
  import fps_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and micro-operation
  always_comb begin
    state_next = state;
    cmd.uop    = U_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.uop    = U_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_MAKE_READY:
            if (!stat.tgt_ok) state_next = S_FIN;
            else if (stat.subj_in_blk) state_next = S_RM_INIT_B;
            else state_next = S_ADD_R;
          MODE_BLOCK_CHILD: state_next = stat.tgt_ok ? S_BOC_W : S_FIN;
          MODE_SEM_CREATE:  state_next = S_CREATE;
          MODE_SEM_P:       state_next = stat.sem_ok ? S_P_RD : S_FIN;
          MODE_SEM_V:       state_next = stat.sem_ok ? S_V_RD : S_FIN;
          MODE_SCHEDULE:    state_next = S_WK_INIT;
          MODE_SET_STATUS:  state_next = S_SET;
          default:          state_next = S_FIN;
        endcase
      end
      S_MR_CLR: begin cmd.uop = U_MR_CLR; state_next = S_ADD_R; end
      S_BOC_W: begin
        cmd.uop    = U_BOC_W;
        state_next = stat.subj_in_rdy ? S_RM_INIT_R : S_ADD_B;
      end
      S_CREATE: begin cmd.uop = U_CREATE; state_next = S_FIN; end
      S_P_RD:   begin cmd.uop = U_P_RD; state_next = S_P_CHK; end
      S_P_CHK: begin
        cmd.uop = U_P_CHK;
        if (!stat.cnt_nonzero && stat.run_v) state_next = S_P_BLK;
        else state_next = S_FIN;
      end
      S_P_BLK:  state_next = stat.subj_in_rdy ? S_RM_INIT_R : S_ADD_B;
      S_V_RD:   begin cmd.uop = U_V_RD; state_next = S_V_INC; end
      S_V_INC:  begin cmd.uop = U_V_INC; state_next = S_WK_INIT; end
      S_SET:    begin cmd.uop = U_SET; state_next = S_FIN; end
      S_RM_INIT_R: begin cmd.uop = U_RM_INIT_R; state_next = S_RM_RD; end
      S_RM_INIT_B: begin cmd.uop = U_RM_INIT_B; state_next = S_RM_RD; end
      S_RM_RD:  begin cmd.uop = U_RM_RD; state_next = S_RM_CHK; end
      S_RM_CHK: begin
        cmd.uop = U_RM_CHK;
        if (!stat.rm_hit) state_next = S_RM_RD;
        else if (stat.mode == MODE_MAKE_READY) state_next = S_MR_CLR;
        else state_next = S_ADD_B;
      end
      S_ADD_R: begin
        cmd.uop    = U_ADD_R;
        state_next = (stat.mode == MODE_MAKE_READY) ? S_FIN : S_WK_TEST;
      end
      S_ADD_B: begin
        cmd.uop    = U_ADD_B;
        state_next = (stat.mode == MODE_BLOCK_CHILD) ? S_FIN : S_WK_INIT;
      end
      S_WK_INIT: begin cmd.uop = U_WK_INIT; state_next = S_WK_TEST; end
      S_WK_TEST: begin
        cmd.uop = U_WK_TEST;
        if (!stat.cnt_zero) state_next = S_WK_GET;
        else if (stat.mode == MODE_SEM_V) state_next = S_FIN;
        else state_next = S_DISP;
      end
      S_WK_GET: begin
        cmd.uop = U_WK_GET;
        if (!stat.wk_cand) state_next = S_WK_TEST;
        else if (stat.mode == MODE_SEM_V) state_next = S_WK_S;
        else state_next = S_WK_Z;
      end
      S_WK_Z: begin
        cmd.uop    = U_WK_Z;
        state_next = stat.st_zombie ? S_WK_UNLINK : S_WK_TEST;
      end
      S_WK_S: begin
        cmd.uop    = U_WK_S;
        state_next = stat.cnt_nonzero ? S_WK_UNLINK : S_WK_TEST;
      end
      S_WK_UNLINK: begin cmd.uop = U_WK_UNLINK; state_next = S_ADD_R; end
      S_DISP: begin
        cmd.uop    = U_DISP;
        state_next = stat.rdy_empty ? S_SC_RD : S_DISP2;
      end
      S_DISP2:  begin cmd.uop = U_DISP2; state_next = S_FIN; end
      S_SC_RD:  begin cmd.uop = U_SC_RD; state_next = S_SC_CHK; end
      S_SC_CHK: begin
        cmd.uop    = U_SC_CHK;
        state_next = stat.sc_stop ? S_FIN : S_SC_RD;
      end
      S_FIN:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);

  `FPS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `FPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

endmodule

>>> design/fifo_process_scheduler_semaphores.sv
// one transaction at a time, taken when start is high and busy is low
// done follows the steps of each operation: create, set_status and a plain make_ready
// apply their update right after decode, a P that takes a unit reads the count and then
// checks it, list removal walks entry by entry, the wake walk visits each blocked entry
// and the idle scan checks each slot; result ports valid for the single cycle done is high;
// receiver cannot stall; synchronous reset: all processes free, lists empty, no semaphores, none running
module fifo_process_scheduler_semaphores #(
  parameter int PROC_SLOTS = 32,
  parameter int SEM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [4:0]  target_proc,
  input  logic [4:0]  child_proc,
  input  logic [3:0]  sem_select,
  input  logic [15:0] sem_init,
  input  logic [2:0]  new_status,
  output logic        done,
  output logic [1:0]  result_code,
  output logic        run_valid,
  output logic [4:0]  run_proc,
  output logic [3:0]  sem_created
);
  import fps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  fps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  // tables, lists and counts
  fps_dp #(
    .PROC_SLOTS (PROC_SLOTS),
    .SEM_SLOTS  (SEM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .target_proc (target_proc),
    .child_proc  (child_proc),
    .sem_select  (sem_select),
    .sem_init    (sem_init),
    .new_status  (new_status),
    .result_code (result_code),
    .run_valid   (run_valid),
    .run_proc    (run_proc),
    .sem_created (sem_created)
  );

endmodule

>>> sim/tb_fifo_process_scheduler_semaphores.sv
`timescale 1ns / 100ps

module tb_fifo_process_scheduler_semaphores;
  import fps_pkg::*;

  localparam int NPROC      = 32;
  localparam int NSEM       = 16;
  localparam int CNT_MAX    = 65535;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 515;
  localparam int N_DIRECTED = 22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [4:0]  target_proc = '0;
  logic [4:0]  child_proc = '0;
  logic [3:0]  sem_select = '0;
  logic [15:0] sem_init = '0;
  logic [2:0]  new_status = '0;
  logic        done;
  logic [1:0]  result_code;
  logic        run_valid;
  logic [4:0]  run_proc;
  logic [3:0]  sem_created;

  fifo_process_scheduler_semaphores dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .target_proc(target_proc), .child_proc(child_proc),
    .sem_select(sem_select), .sem_init(sem_init), .new_status(new_status),
    .done(done), .result_code(result_code), .run_valid(run_valid),
    .run_proc(run_proc), .sem_created(sem_created)
  );

  always #6 clk = ~clk;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  tgt;
    logic [4:0]  child;
    logic [3:0]  sem;
    logic [15:0] init;
    logic [2:0]  status;
  } op_t;

  typedef struct packed {
    logic [1:0] code;
    logic       rv;
    logic [4:0] rp;
    logic [3:0] sc;
  } outcome_t;

  // directed row: operation, literal expected outcome if known
  typedef struct packed {
    op_t      op;
    logic     fixed;
    outcome_t want;
  } row_t;

  // scheduler shadow state
  logic [2:0]  pstat [NPROC];
  logic [4:0]  link [NPROC];
  logic [4:0]  child_of [NPROC];
  logic        child_v [NPROC];
  logic [3:0]  sem_of [NPROC];
  logic        sem_v [NPROC];
  int          rdy_head, rdy_tail, rdy_len;
  int          blk_head, blk_tail, blk_len;
  int          cnt [NSEM];
  int          sems_used;
  int          running;
  logic        running_v;

  outcome_t    pending_results[$];
  int          errors = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        sender_done = 1'b0;
  logic        rx_ok;

  function automatic logic on_ready(int p);
    int cur;
    cur = rdy_head;
    for (int i = 0; i < rdy_len; i++) begin
      if (cur == p) return 1'b1;
      cur = int'(link[cur]);
    end
    return 1'b0;
  endfunction

  function automatic logic on_blocked(int p);
    int cur;
    cur = blk_head;
    for (int i = 0; i < blk_len; i++) begin
      if (cur == p) return 1'b1;
      cur = int'(link[cur]);
    end
    return 1'b0;
  endfunction

  // unlink p from ready list (sel 0) or blocked list (sel 1)
  task automatic unlink(int sel, int p);
    int cur, prev, n, nxt;
    cur = sel ? blk_head : rdy_head;
    n = sel ? blk_len : rdy_len;
    prev = 0;
    for (int i = 0; i < n; i++) begin
      if (cur == p) begin
        nxt = int'(link[cur]);
        if (i == 0) begin
          if (sel) blk_head = nxt; else rdy_head = nxt;
        end else begin
          link[prev] = 5'(nxt);
        end
        if (i + 1 == n) begin
          if (sel) blk_tail = prev; else rdy_tail = prev;
        end
        if (sel) blk_len--; else rdy_len--;
        return;
      end
      prev = cur;
      cur = int'(link[cur]);
    end
  endtask

  task automatic push_ready(int p);
    if (!on_ready(p)) begin
      if (rdy_len == 0) rdy_head = p; else link[rdy_tail] = 5'(p);
      rdy_tail = p;
      rdy_len++;
      pstat[p] = ST_READY;
    end
  endtask

  task automatic push_blocked(int p);
    if (!on_blocked(p)) begin
      if (blk_len == 0) blk_head = p; else link[blk_tail] = 5'(p);
      blk_tail = p;
      blk_len++;
      pstat[p] = ST_BLOCKED;
    end
  endtask

  task automatic dispatch(inout outcome_t r);
    int n, cur, p, h;
    logic live;
    n = blk_len;
    cur = blk_head;
    // wake every waiter whose child is a zombie
    for (int i = 0; i < n; i++) begin
      p = cur;
      cur = int'(link[p]);
      if (child_v[p] && pstat[child_of[p]] == ST_ZOMBIE) begin
        child_v[p] = 1'b0;
        unlink(1, p);
        push_ready(p);
      end
    end
    if (rdy_len == 0) begin
      running_v = 1'b0;
      live = 1'b0;
      for (int i = 0; i < NPROC; i++)
        if (pstat[i] != ST_FREE && pstat[i] != ST_ZOMBIE) live = 1'b1;
      r.code = live ? RC_STUCK : RC_SHUTDOWN;
      return;
    end
    h = rdy_head;
    rdy_head = int'(link[h]);
    rdy_len--;
    pstat[h] = ST_RUNNING;
    running = h;
    running_v = 1'b1;
    r.rv = 1'b1;
    r.rp = h[4:0];
  endtask

  // advance the shadow scheduler by one operation
  task automatic apply_op(input op_t op, output outcome_t r);
    int n, cur, p, w, s, t;
    r = '0;
    s = int'(op.sem);
    t = int'(op.tgt);
    case (op.mode)
      MODE_MAKE_READY: begin
        if (on_blocked(t)) begin
          unlink(1, t);
          child_v[t] = 1'b0;
          sem_v[t] = 1'b0;
        end
        push_ready(t);
      end
      MODE_BLOCK_CHILD: begin
        child_of[t] = op.child;
        child_v[t] = 1'b1;
        sem_v[t] = 1'b0;
        unlink(0, t);
        push_blocked(t);
      end
      MODE_SEM_CREATE: begin
        if (sems_used >= NSEM) begin
          r.code = RC_FULL;
        end else begin
          cnt[sems_used] = int'(op.init);
          r.sc = sems_used[3:0];
          sems_used++;
        end
      end
      MODE_SEM_P: begin
        if (cnt[s] >= 1) begin
          cnt[s]--;
        end else if (running_v) begin
          sem_of[running] = op.sem;
          sem_v[running] = 1'b1;
          child_v[running] = 1'b0;
          unlink(0, running);
          push_blocked(running);
          dispatch(r);
        end
      end
      MODE_SEM_V: begin
        if (cnt[s] < CNT_MAX) cnt[s]++;
        n = blk_len;
        cur = blk_head;
        for (int i = 0; i < n; i++) begin
          p = cur;
          cur = int'(link[p]);
          if (sem_v[p]) begin
            w = int'(sem_of[p]);
            if (cnt[w] >= 1) begin
              cnt[w]--;
              sem_v[p] = 1'b0;
              unlink(1, p);
              push_ready(p);
            end
          end
        end
      end
      MODE_SCHEDULE: dispatch(r);
      MODE_SET_STATUS: if (op.status <= ST_ZOMBIE) pstat[t] = op.status;
      default: ;
    endcase
  endtask

  function automatic op_t mk(logic [2:0] m, int t, int c, int s, int i, int st);
    op_t o;
    o.mode = m; o.tgt = 5'(t); o.child = 5'(c); o.sem = 4'(s); o.init = 16'(i);
    o.status = 3'(st);
    return o;
  endfunction

  // random operation; the semaphore index of a P or V is kept below the created count
  function automatic op_t rand_op();
    op_t o;
    int k;
    o.tgt = 5'($urandom_range(0, 31));
    o.child = 5'($urandom_range(0, 31));
    o.init = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) o.init = $urandom_range(0, 1) ? 16'hffff : 16'h0;
    o.status = 3'($urandom_range(0, 7));
    k = $urandom_range(0, 99);
    if (k < 22) o.mode = MODE_MAKE_READY;
    else if (k < 32) o.mode = MODE_BLOCK_CHILD;
    else if (k < 36) o.mode = MODE_SEM_CREATE;
    else if (k < 50) o.mode = MODE_SEM_P;
    else if (k < 62) o.mode = MODE_SEM_V;
    else if (k < 84) o.mode = MODE_SCHEDULE;
    else if (k < 98) o.mode = MODE_SET_STATUS;
    else o.mode = MODE_UNUSED;
    if (o.mode == MODE_SET_STATUS && $urandom_range(0, 1)) o.status = ST_ZOMBIE;
    if (sems_used == 0) begin
      if (o.mode == MODE_SEM_P || o.mode == MODE_SEM_V) o.mode = MODE_SEM_CREATE;
      o.sem = 4'($urandom_range(0, 15));
    end else begin
      o.sem = 4'($urandom_range(0, sems_used - 1));
    end
    // untouched ops still toggle every semaphore bit
    if (o.mode != MODE_SEM_P && o.mode != MODE_SEM_V) o.sem = 4'($urandom_range(0, 15));
    return o;
  endfunction

  // drive one transaction and wait for it to be taken
  task automatic send(input op_t op);
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b1;
    mode <= op.mode;
    target_proc <= op.tgt;
    child_proc <= op.child;
    sem_select <= op.sem;
    sem_init <= op.init;
    new_status <= op.status;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  // one transaction handed out per call, with the expected outcome queued
  task automatic issue(input op_t op, input logic fixed, input outcome_t want,
                       input logic gaps);
    outcome_t r;
    if (gaps) while ($urandom_range(0, 99) < 38) @(posedge clk);
    apply_op(op, r);
    if (fixed && r !== want) begin
      errors++;
      $display("directed row disagrees with shadow: mode %0d", op.mode);
    end
    pending_results.push_back(fixed ? want : r);
    send(op);
  endtask

  row_t directed [N_DIRECTED];

  initial begin
    for (int i = 0; i < NPROC; i++) begin
      pstat[i] = ST_FREE; link[i] = '0; child_of[i] = '0; child_v[i] = 1'b0;
      sem_of[i] = '0; sem_v[i] = 1'b0;
    end
    for (int i = 0; i < NSEM; i++) cnt[i] = 0;
    rdy_head = 0; rdy_tail = 0; rdy_len = 0;
    blk_head = 0; blk_tail = 0; blk_len = 0;
    sems_used = 0; running = 0; running_v = 1'b0;

    directed[0]  = '{mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), 1'b1, '{RC_SHUTDOWN, 0, 0, 0}};
    directed[1]  = '{mk(MODE_UNUSED, 31, 31, 15, 16'hffff, 7), 1'b1, '{RC_OK, 0, 0, 0}};
    directed[2]  = '{mk(MODE_SEM_CREATE, 0, 0, 0, 16'hffff, 0), 1'b1, '{RC_OK, 0, 0, 0}};
    directed[3]  = '{mk(MODE_SEM_CREATE, 0, 0, 0, 0, 0), 1'b1, '{RC_OK, 0, 0, 1}};
    directed[4]  = '{mk(MODE_SEM_V, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[5]  = '{mk(MODE_SEM_P, 0, 0, 1, 0, 0), 1'b1, '{RC_OK, 0, 0, 0}};
    directed[6]  = '{mk(MODE_MAKE_READY, 31, 0, 0, 0, 0), 1'b0, '0};
    directed[7]  = '{mk(MODE_MAKE_READY, 31, 0, 0, 0, 0), 1'b0, '0};
    directed[8]  = '{mk(MODE_MAKE_READY, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[9]  = '{mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), 1'b1, '{RC_OK, 1, 31, 0}};
    directed[10] = '{mk(MODE_SEM_P, 0, 0, 1, 0, 0), 1'b1, '{RC_OK, 1, 0, 0}};
    directed[11] = '{mk(MODE_BLOCK_CHILD, 0, 5, 0, 0, 0), 1'b0, '0};
    directed[12] = '{mk(MODE_BLOCK_CHILD, 0, 5, 0, 0, 0), 1'b0, '0};
    directed[13] = '{mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), 1'b1, '{RC_STUCK, 0, 0, 0}};
    directed[14] = '{mk(MODE_SET_STATUS, 5, 0, 0, 0, 4), 1'b0, '0};
    directed[15] = '{mk(MODE_SET_STATUS, 5, 0, 0, 0, 7), 1'b0, '0};
    directed[16] = '{mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[17] = '{mk(MODE_SEM_V, 0, 0, 1, 0, 0), 1'b0, '0};
    directed[18] = '{mk(MODE_MAKE_READY, 31, 0, 0, 0, 0), 1'b0, '0};
    directed[19] = '{mk(MODE_SCHEDULE, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[20] = '{mk(MODE_SEM_P, 0, 0, 0, 0, 0), 1'b0, '0};
    directed[21] = '{mk(MODE_SET_STATUS, 31, 31, 0, 0, 0), 1'b0, '0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      issue(directed[i].op, directed[i].fixed, directed[i].want, 1'b1);

    // fill the semaphore table, then the full case
    while (sems_used < NSEM) issue(mk(MODE_SEM_CREATE, 0, 0, 0,
                                      $urandom_range(0, 2), 0), 1'b0, '0, 1'b1);
    issue(mk(MODE_SEM_CREATE, 0, 0, 0, 0, 0), 1'b1, '{RC_FULL, 0, 0, 0}, 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      // hold off until everything has drained
      if (i == 200) while (pending_results.size() != 0) @(posedge clk);
      issue(rand_op(), 1'b0, '0, !(i >= 300 && i < 400));
    end
    sender_done <= 1'b1;
  end

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result code %0d", result_code);
      end else begin
        w = pending_results.pop_front();
        if (result_code !== w.code || run_valid !== w.rv || run_proc !== w.rp ||
            sem_created !== w.sc) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp code %0d rv %0d rp %0d sc %0d, got %0d %0d %0d %0d",
                     w.code, w.rv, w.rp, w.sc, result_code, run_valid, run_proc,
                     sem_created);
        end
      end
    end
  end

  // watchdog on cycles without a transaction
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    rx_ok = (errors == 0) && (pending_results.size() == 0);
    if (rx_ok) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/fps_pkg.sv
design/fps_dp.sv
design/fps_ctrl.sv
design/fifo_process_scheduler_semaphores.sv
sim/tb_fifo_process_scheduler_semaphores.sv
